// ===== rtl/level_priority_page_cache_core_macros.svh =====
// Assertion macros for the level priority page cache core.
`ifndef LEVEL_PRIORITY_PAGE_CACHE_CORE_MACROS_SVH
`define LEVEL_PRIORITY_PAGE_CACHE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LPPC_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LPPC_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== rtl/lppc_pkg.sv =====
// Shared types and constants of the level priority page cache.
package lppc_pkg;

  localparam int CachePages = 16;
  localparam int SlotW      = (CachePages > 1) ? $clog2(CachePages) : 1;
  localparam int SlotOutW   = 4;
  localparam int CfgW       = 5;
  localparam int CmpW       = SlotW + CfgW + 1;
  localparam int OpW        = 2;
  localparam int IdW        = 32;
  localparam int LvlW       = 8;
  localparam logic [CfgW-1:0] PagesReset = CfgW'(16);

  typedef enum logic [OpW-1:0] {
    OP_GET  = 2'd0,
    OP_SAVE = 2'd1,
    OP_FREE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctrl_sts_t;

endpackage

// ===== rtl/lppc_ctrl.sv =====
// Request sequencer: accept, slot walk, commit and result handshake.
module lppc_ctrl
  import lppc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.start  = 1'b0;
    cmd_o.scan   = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/lppc_dp.sv =====
// Datapath: entry store, slot walk compare unit, result register, config.
module lppc_dp
  import lppc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_sts_t           sts_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [OpW-1:0]      operation_i,
  input  logic [IdW-1:0]      node_id_i,
  input  logic [LvlW-1:0]     level_i,
  output logic                hit_o,
  output logic [SlotOutW-1:0] slot_o,
  output logic                disk_read_o,
  output logic                placed_o,
  output logic                evicted_o,
  output logic [IdW-1:0]      evicted_id_o,
  output logic                write_through_o,
  output logic                freed_o
);

  logic [CfgW-1:0]  pages_q;
  logic [CachePages-1:0] entry_valid_q;
  logic [IdW-1:0]   entry_id_q    [CachePages];
  logic [LvlW-1:0]  entry_level_q [CachePages];

  logic [OpW-1:0]   req_op_q;
  logic [IdW-1:0]   req_id_q;
  logic [LvlW-1:0]  req_lvl_q;

  logic [SlotW-1:0] idx_q;
  logic             hit_q;
  logic [SlotW-1:0] hit_slot_q;
  logic             free_q;
  logic [SlotW-1:0] free_slot_q;
  logic             have_q;
  logic [SlotW-1:0] best_slot_q;
  logic [LvlW-1:0]  best_lvl_q;
  logic [IdW-1:0]   best_id_q;

  logic             hit_q_o, disk_read_q, placed_q, evicted_q, wt_q, freed_q;
  logic [SlotW-1:0] slot_q;
  logic [IdW-1:0]   evicted_id_q;

  logic             cur_valid;
  logic [IdW-1:0]   cur_id;
  logic [LvlW-1:0]  cur_lvl;
  logic [CmpW-1:0]  act_slots;
  logic             in_lim;
  logic             better;

  logic             res_hit, res_disk, res_placed, res_evict, res_wt, res_freed;
  logic [SlotW-1:0] res_slot;
  logic [IdW-1:0]   res_evict_id;
  logic             wr_en, clr_en;
  logic             is_get;

  assign cfg_ready_o     = 1'b1;
  assign sts_o.scan_last = (idx_q == SlotW'(CachePages - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q <= PagesReset;
    end else if (cfg_valid_i) begin
      pages_q <= cfg_data_i;
    end
  end

  // slot walk: one entry compared per cycle
  assign cur_valid = entry_valid_q[idx_q];
  assign cur_id    = entry_id_q[idx_q];
  assign cur_lvl   = entry_level_q[idx_q];
  assign act_slots = (CmpW'(pages_q) < CmpW'(CachePages)) ? CmpW'(pages_q)
                                                           : CmpW'(CachePages);
  assign in_lim    = CmpW'(idx_q) < act_slots;
  assign better    = !have_q || (cur_lvl < best_lvl_q) ||
                     ((cur_lvl == best_lvl_q) && (cur_id < best_id_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      have_q <= 1'b0;
    end else if (cmd_i.start) begin
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      have_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + SlotW'(1);
      if (cur_valid && (cur_id == req_id_q) && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (in_lim && !cur_valid && !free_q) begin
        free_q <= 1'b1;
      end
      if (in_lim && better) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_op_q  <= operation_i;
      req_id_q  <= node_id_i;
      req_lvl_q <= level_i;
    end
    if (cmd_i.scan) begin
      if (cur_valid && (cur_id == req_id_q) && !hit_q) begin
        hit_slot_q <= idx_q;
      end
      if (in_lim && !cur_valid && !free_q) begin
        free_slot_q <= idx_q;
      end
      if (in_lim && better) begin
        best_slot_q <= idx_q;
        best_lvl_q  <= cur_lvl;
        best_id_q   <= cur_id;
      end
    end
  end

  // decide the outcome from the walk summary
  always_comb begin
    res_hit      = 1'b0;
    res_disk     = 1'b0;
    res_placed   = 1'b0;
    res_evict    = 1'b0;
    res_wt       = 1'b0;
    res_freed    = 1'b0;
    res_slot     = '0;
    res_evict_id = '0;
    wr_en        = 1'b0;
    clr_en       = 1'b0;
    is_get       = (req_op_q == OP_GET);
    case (op_e'(req_op_q))
      OP_FREE: begin
        if (hit_q) begin
          clr_en    = 1'b1;
          res_hit   = 1'b1;
          res_slot  = hit_slot_q;
          res_freed = 1'b1;
        end
      end
      OP_GET, OP_SAVE: begin
        if (pages_q == '0) begin
          res_disk = is_get;
          res_wt   = !is_get;
        end else if (hit_q) begin
          res_hit  = 1'b1;
          res_slot = hit_slot_q;
        end else begin
          if (free_q) begin
            wr_en      = 1'b1;
            res_placed = 1'b1;
            res_slot   = free_slot_q;
          end else if (have_q && (best_lvl_q <= req_lvl_q)) begin
            wr_en        = 1'b1;
            res_placed   = 1'b1;
            res_evict    = 1'b1;
            res_evict_id = best_id_q;
            res_slot     = best_slot_q;
          end
          res_disk = is_get;
          res_wt   = !is_get && !res_placed;
        end
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
    end else if (cmd_i.commit && clr_en) begin
      entry_valid_q[res_slot] <= 1'b0;
    end else if (cmd_i.commit && wr_en) begin
      entry_valid_q[res_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      entry_id_q[res_slot]    <= req_id_q;
      entry_level_q[res_slot] <= req_lvl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q_o      <= res_hit;
      slot_q       <= res_slot;
      disk_read_q  <= res_disk;
      placed_q     <= res_placed;
      evicted_q    <= res_evict;
      evicted_id_q <= res_evict_id;
      wt_q         <= res_wt;
      freed_q      <= res_freed;
    end
  end

  assign hit_o           = hit_q_o;
  assign slot_o          = SlotOutW'(slot_q);
  assign disk_read_o     = disk_read_q;
  assign placed_o        = placed_q;
  assign evicted_o       = evicted_q;
  assign evicted_id_o    = evicted_id_q;
  assign write_through_o = wt_q;
  assign freed_o         = freed_q;

endmodule

// ===== rtl/level_priority_page_cache_core.sv =====
// A request walks all slots in ST_SCAN, then ST_COMMIT waits for a free result register.
// Requests are taken only in ST_IDLE; a single compare unit walks the slots one per cycle.
// A new request is taken while the previous result beat still waits in the output register.
// Reset: valid bits cleared, pages_q set to 16, no clearing pass; config taken any cycle.
// Top level: sequencer and datapath of the level priority page cache.
`include "level_priority_page_cache_core_macros.svh"
module level_priority_page_cache_core
  import lppc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OpW-1:0]      operation_i,
  input  logic [IdW-1:0]      node_id_i,
  input  logic [LvlW-1:0]     level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic [SlotOutW-1:0] slot_o,
  output logic                disk_read_o,
  output logic                placed_o,
  output logic                evicted_o,
  output logic [IdW-1:0]      evicted_id_o,
  output logic                write_through_o,
  output logic                freed_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lppc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lppc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .node_id_i       (node_id_i),
    .level_i         (level_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .disk_read_o     (disk_read_o),
    .placed_o        (placed_o),
    .evicted_o       (evicted_o),
    .evicted_id_o    (evicted_id_o),
    .write_through_o (write_through_o),
    .freed_o         (freed_o)
  );

  `LPPC_ASSERT_IMP(a_commit_slot_free, cmd.commit, !out_valid_o || out_ready_i, "result overrun")
  `LPPC_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_o, "commit did not raise the beat")
  `LPPC_ASSERT_IMP(a_start_on_accept, cmd.start, in_valid_i && in_ready_o, "start without beat")
  `LPPC_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready while busy")

endmodule

// ===== tb/sv/level_priority_page_cache_core_tb.sv =====
// Testbench for the page cache core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module level_priority_page_cache_core_tb;
  import lppc_pkg::*;

  localparam logic [OpW-1:0] OpReserved = 2'd3;

  typedef struct {
    logic                hit;
    logic [SlotOutW-1:0] slot;
    logic                disk_read;
    logic                placed;
    logic                evicted;
    logic [IdW-1:0]      evicted_id;
    logic                write_through;
    logic                freed;
  } cache_answer_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OpW-1:0]      operation_i;
  logic [IdW-1:0]      node_id_i;
  logic [LvlW-1:0]     level_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                hit_o;
  logic [SlotOutW-1:0] slot_o;
  logic                disk_read_o;
  logic                placed_o;
  logic                evicted_o;
  logic [IdW-1:0]      evicted_id_o;
  logic                write_through_o;
  logic                freed_o;

  logic                slot_valid [CachePages];
  logic [IdW-1:0]      slot_id    [CachePages];
  logic [LvlW-1:0]     slot_level [CachePages];
  logic [CfgW-1:0]     pages_limit;

  cache_answer_t       predicted_answers [$];
  int                  mismatch_count;
  bit                  steady;

  level_priority_page_cache_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .node_id_i      (node_id_i),
    .level_i        (level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .disk_read_o    (disk_read_o),
    .placed_o       (placed_o),
    .evicted_o      (evicted_o),
    .evicted_id_o   (evicted_id_o),
    .write_through_o(write_through_o),
    .freed_o        (freed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("level_priority_page_cache_core regression: fail");
    $finish;
  end

  function automatic cache_answer_t predict_cache_access(logic [OpW-1:0] op,
                                                         logic [IdW-1:0] id,
                                                         logic [LvlW-1:0] lvl);
    cache_answer_t ans;
    int            active;
    int            where;
    int            victim;
    ans    = '{default: '0};
    where  = -1;
    victim = -1;
    active = (pages_limit > CachePages) ? CachePages : int'(pages_limit);
    for (int i = 0; i < CachePages; i++) begin
      if (where < 0 && slot_valid[i] && slot_id[i] == id) where = i;
    end
    if (op == OP_FREE) begin
      if (where >= 0) begin
        slot_valid[where] = 1'b0;
        ans.hit   = 1'b1;
        ans.slot  = SlotOutW'(where);
        ans.freed = 1'b1;
      end
      return ans;
    end
    if (op == OpReserved) return ans;
    if (active == 0) begin
      if (op == OP_GET) ans.disk_read = 1'b1;
      else ans.write_through = 1'b1;
      return ans;
    end
    if (where >= 0) begin
      ans.hit  = 1'b1;
      ans.slot = SlotOutW'(where);
      return ans;
    end
    ans.disk_read = (op == OP_GET);
    for (int i = 0; i < active; i++) begin
      if (victim < 0 && !slot_valid[i]) victim = i;
    end
    if (victim >= 0) begin
      slot_valid[victim] = 1'b1;
      slot_id[victim]    = id;
      slot_level[victim] = lvl;
      ans.slot   = SlotOutW'(victim);
      ans.placed = 1'b1;
      return ans;
    end
    victim = 0;
    for (int i = 1; i < active; i++) begin
      if (slot_level[i] < slot_level[victim] ||
          (slot_level[i] == slot_level[victim] && slot_id[i] < slot_id[victim])) victim = i;
    end
    if (slot_level[victim] <= lvl) begin
      ans.evicted    = 1'b1;
      ans.evicted_id = slot_id[victim];
      slot_id[victim]    = id;
      slot_level[victim] = lvl;
      ans.slot   = SlotOutW'(victim);
      ans.placed = 1'b1;
    end else if (op == OP_SAVE) begin
      ans.write_through = 1'b1;
    end
    return ans;
  endfunction

  function automatic void check_field(string name, logic [IdW-1:0] want, logic [IdW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    cache_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_answers.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        want = predicted_answers.pop_front();
        check_field("hit", IdW'(want.hit), IdW'(hit_o));
        check_field("slot", IdW'(want.slot), IdW'(slot_o));
        check_field("disk_read", IdW'(want.disk_read), IdW'(disk_read_o));
        check_field("placed", IdW'(want.placed), IdW'(placed_o));
        check_field("evicted", IdW'(want.evicted), IdW'(evicted_o));
        check_field("evicted_id", want.evicted_id, evicted_id_o);
        check_field("write_through", IdW'(want.write_through), IdW'(write_through_o));
        check_field("freed", IdW'(want.freed), IdW'(freed_o));
      end
    end
  end

  initial begin
    int stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_request(logic [OpW-1:0] op, logic [IdW-1:0] id, logic [LvlW-1:0] lvl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    node_id_i   <= id;
    level_i     <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_answers.push_back(predict_cache_access(op, id, lvl));
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (predicted_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pages(logic [CfgW-1:0] value);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    pages_limit = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_hit_and_free();
    send_request(OP_GET, 32'h0, 8'd0);
    send_request(OP_GET, 32'h0, 8'd255);
    send_request(OP_SAVE, 32'hFFFF_FFFF, 8'd255);
    send_request(OP_SAVE, 32'hFFFF_FFFF, 8'd0);
    send_request(OP_FREE, 32'h0, 8'd7);
    send_request(OP_FREE, 32'h0, 8'd0);
    send_request(OpReserved, 32'h5, 8'd9);
    send_request(OP_FREE, 32'hFFFF_FFFF, 8'd3);
  endtask

  task automatic test_eviction_priority();
    write_pages(CfgW'(2));
    send_request(OP_SAVE, 32'h20, 8'd5);
    send_request(OP_SAVE, 32'h10, 8'd5);
    send_request(OP_GET, 32'h30, 8'd4);
    send_request(OP_SAVE, 32'h30, 8'd4);
    send_request(OP_GET, 32'h30, 8'd5);
  endtask

  task automatic test_shrunk_limit();
    write_pages(CfgW'(1));
    send_request(OP_GET, 32'h30, 8'd0);
    send_request(OP_SAVE, 32'h40, 8'd255);
    send_request(OP_FREE, 32'h30, 8'd0);
  endtask

  task automatic test_bypass();
    write_pages(CfgW'(0));
    send_request(OP_GET, 32'h50, 8'd1);
    send_request(OP_SAVE, 32'h50, 8'd1);
    send_request(OP_GET, 32'h40, 8'd255);
    send_request(OP_FREE, 32'h40, 8'd0);
  endtask

  task automatic test_wide_limit();
    write_pages(CfgW'(31));
    send_request(OP_SAVE, 32'h60, 8'd9);
    send_request(OP_SAVE, 32'h60, 8'd200);
    send_request(OP_GET, 32'h60, 8'd0);
    write_pages(CfgW'(16));
  endtask

  task automatic test_random_traffic();
    logic [IdW-1:0]  id_pool [20];
    logic [OpW-1:0]  op;
    logic [IdW-1:0]  id;
    logic [LvlW-1:0] lvl;
    int              pick;
    for (int k = 0; k < 20; k++) id_pool[k] = (k < 10) ? IdW'(k) : IdW'($urandom());
    for (int phase = 0; phase < 37; phase++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: write_pages(CfgW'($urandom_range(0, 31)));
        1, 2: write_pages(CfgW'($urandom_range(1, 4)));
        3: write_pages(CfgW'(16));
        4: write_pages(CfgW'($urandom_range(5, 15)));
        default: ;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 19);
        op = (pick < 8) ? OP_GET : (pick < 15) ? OP_SAVE : (pick < 19) ? OP_FREE : OpReserved;
        pick = $urandom_range(0, 9);
        id = (pick < 7) ? id_pool[$urandom_range(0, 19)] :
             (pick < 9) ? IdW'($urandom_range(0, 7)) : IdW'($urandom());
        pick = $urandom_range(0, 9);
        lvl = (pick < 5) ? LvlW'($urandom_range(0, 3)) :
              (pick < 8) ? LvlW'($urandom_range(0, 255)) :
              (pick == 8) ? LvlW'(0) : LvlW'(255);
        send_request(op, id, lvl);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    steady         = 1'b0;
    pages_limit    = PagesReset;
    for (int i = 0; i < CachePages; i++) begin
      slot_valid[i] = 1'b0;
      slot_id[i]    = '0;
      slot_level[i] = '0;
    end
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_GET;
    node_id_i   <= '0;
    level_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hit_and_free();
    test_eviction_priority();
    test_shrunk_limit();
    test_bypass();
    test_wide_limit();
    test_random_traffic();

    drain_requests();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("level_priority_page_cache_core regression: pass");
    end else begin
      $display("level_priority_page_cache_core regression: fail");
    end
    $finish;
  end

endmodule
